[rtl/tefs_pkg.sv]
// Shared types, constants and character helpers for the escape and fence stripper.
package tefs_pkg;

   localparam int BLANK_DEPTH_DEF = 16;
   localparam int TAG_DEPTH_DEF   = 32;
   localparam int PREFIX_LEN      = 15;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QAW             = $clog2(QUEUE_DEPTH);
   localparam int SEG_COUNT       = 10;
   // Count widths cover the whole legal range of the depth parameters.
   localparam int BCW             = 7;
   localparam int TCW             = 6;
   localparam int IDXW            = 7;
   localparam int NEMW            = 6;

   localparam logic [7:0] BEL_CHAR = 8'h07;
   localparam logic [7:0] TAB_CHAR = 8'h09;
   localparam logic [7:0] NL_CHAR  = 8'h0A;
   localparam logic [7:0] CR_CHAR  = 8'h0D;
   localparam logic [7:0] ESC_CHAR = 8'h1B;
   localparam logic [7:0] SP_CHAR  = 8'h20;
   localparam logic [7:0] QT_CHAR  = 8'h27;
   localparam logic [7:0] BSL_CHAR = 8'h5C;
   localparam logic [7:0] RBR_CHAR = 8'h5D;
   localparam logic [7:0] US_CHAR  = 8'h5F;

   typedef enum logic [2:0] {
      PH_TEXT,
      PH_ESC,
      PH_OSC,
      PH_OSC_ESC,
      PH_TAG,
      PH_TAG_US
   } phase_type;

   typedef enum logic [3:0] {
      SEG_BLANK,
      SEG_ESC_A,
      SEG_PFX_A,
      SEG_TAG_A,
      SEG_C,
      SEG_PFX_B,
      SEG_ESC_B,
      SEG_TAG_B,
      SEG_NL,
      SEG_BARE
   } seg_type;

   typedef struct packed {
      phase_type      phase;
      logic [3:0]     pm;
      logic [TCW-1:0] tc;
      logic [BCW-1:0] bc;
      logic           als;
      logic           wr;
      logic           cm;
   } front_state_type;

   localparam front_state_type FRONT_RESET = '{
      phase: PH_TEXT, pm: 4'd0, tc: '0, bc: '0, als: 1'b1, wr: 1'b0, cm: 1'b0
   };

   // One command per accepted byte: store write plus the ordered output segments.
   typedef struct packed {
      logic [7:0]      c;
      logic            wr_tag;
      logic            wr_blank;
      logic [IDXW-1:0] wr_idx;
      logic [BCW-1:0]  nb;
      logic            esc_a;
      logic [3:0]      pa;
      logic [TCW-1:0]  ta;
      logic            emit_c;
      logic [3:0]      pb;
      logic            esc_b;
      logic [TCW-1:0]  tb;
      logic            nl;
      logic            bare;
      logic            ovf;
      logic            eot;
   } cmd_type;

   typedef struct packed {
      seg_type         seg;
      logic [IDXW-1:0] idx;
      logic [7:0]      c;
      logic            last;
      logic            eot;
      logic            ovf;
   } slot_type;

   function automatic logic [7:0] prefix_byte(input logic [3:0] i);
      logic [7:0] b;
      unique case (i)
         4'd0, 4'd1, 4'd8, 4'd14: b = US_CHAR;
         4'd2:                    b = 8'h48;
         4'd3, 4'd6, 4'd10, 4'd13: b = 8'h45;
         4'd4:                    b = 8'h52;
         4'd5:                    b = 8'h4D;
         4'd7:                    b = 8'h53;
         4'd9:                    b = 8'h46;
         4'd11:                   b = 8'h4E;
         4'd12:                   b = 8'h43;
         default:                 b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == SP_CHAR || c == TAB_CHAR || c == CR_CHAR || c == QT_CHAR;
   endfunction

   // Longest tail of the matched prefix plus the new byte that still starts the prefix.
   function automatic logic [3:0] keep_len(input logic [3:0] k, input logic [7:0] c);
      logic [3:0] res;
      logic       ok;
      logic [4:0] idx;
      logic [7:0] sb;
      res = 4'd0;
      for (int j = 1; j < PREFIX_LEN; j++) begin
         ok = (4'(j) <= k);
         for (int i = 0; i < PREFIX_LEN - 1; i++) begin
            if (i < j) begin
               idx = 5'(k) + 5'd1 - 5'(j) + 5'(i);
               sb  = (idx < 5'(k)) ? prefix_byte(idx[3:0]) : c;
               if (sb != prefix_byte(4'(i))) ok = 1'b0;
            end
         end
         if (ok) res = 4'(j);
      end
      return res;
   endfunction

endpackage

[rtl/terminal_escape_fence_stripper.sv]
// Top level of the terminal escape and fence marker stripper.
//
//   channel | direction | tdata          | tlast       | tuser (low bit first)
//   req_    | in        | text_byte      | end_of_text | -
//   rsp_    | out       | out_byte       | run_last    | has_byte, text_done, hold_overflow
//
// The front end classifies one byte per cycle while the queue has room and writes one
// command to a four-entry queue. The output sequencer then walks that command's
// results in order, so the sustained rate is one byte per cycle for plain text while
// the output takes results, and the result count sets it during flushes of held bytes.
// A result passes through the queue, the slot register and the output register.
// Reset is synchronous and returns the block to the start of a line of text.
// Either side may stall freely: the queue and the output register decouple them.
module terminal_escape_fence_stripper import tefs_pkg::*; #(
   parameter int BLANK_DEPTH = BLANK_DEPTH_DEF,
   parameter int TAG_DEPTH   = TAG_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // text_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,   // run_last
   output logic [2:0] rsp_tuser    // has_byte, text_done, hold_overflow
);

   cmd_type cmd, head_cmd;
   logic    full, head_valid, pop, accept;
   logic    out_has, out_done, out_ovf;

   // A byte is taken whenever the queue has room for its command.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   tefs_front #(
      .BLANK_DEPTH (BLANK_DEPTH),
      .TAG_DEPTH   (TAG_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .accept      (accept),
      .cmd         (cmd)
   );

   tefs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_cmd   (cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The back end owns both hold stores, so store writes and reads stay in order.
   tefs_back #(
      .BLANK_DEPTH (BLANK_DEPTH),
      .TAG_DEPTH   (TAG_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_has    (out_has),
      .out_last   (rsp_tlast),
      .out_done   (out_done),
      .out_ovf    (out_ovf)
   );

   assign rsp_tuser = {out_ovf, out_done, out_has};

endmodule

[rtl/tefs_front.sv]
// Front end: scans each byte, tracks line state and builds one output command.
module tefs_front import tefs_pkg::*; #(
   parameter int BLANK_DEPTH = BLANK_DEPTH_DEF,
   parameter int TAG_DEPTH   = TAG_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   input  logic       accept,
   output cmd_type    cmd
);

   localparam logic [TCW-1:0] TAG_BODY_MAX = TCW'(TAG_DEPTH - 1);
   localparam logic [TCW-1:0] TAG_FULL     = TCW'(TAG_DEPTH);
   localparam logic [BCW-1:0] BLANK_FULL   = BCW'(BLANK_DEPTH);

   front_state_type state_ff, state_in;

   always_comb begin
      front_state_type s;
      cmd_type         d;
      logic            put_nb;
      logic            put_c;
      logic            do_text;
      logic            endp;
      logic [3:0]      keep;
      s       = state_ff;
      d       = '0;
      d.c     = text_byte;
      d.eot   = end_of_text;
      put_nb  = 1'b0;
      put_c   = 1'b0;
      do_text = 1'b0;
      endp    = 1'b0;
      keep    = 4'd0;

      if (text_byte != NL_CHAR) begin
         unique case (s.phase)
            PH_OSC: begin
               if (text_byte == BEL_CHAR) s.phase = PH_TEXT;
               else if (text_byte == ESC_CHAR) s.phase = PH_OSC_ESC;
            end
            PH_OSC_ESC: begin
               if (text_byte == BSL_CHAR || text_byte == BEL_CHAR) s.phase = PH_TEXT;
               else if (text_byte != ESC_CHAR) s.phase = PH_OSC;
            end
            PH_ESC: begin
               if (text_byte == RBR_CHAR) begin
                  if (s.als) s.wr = 1'b1;
                  s.als   = 1'b0;
                  s.phase = PH_OSC;
               end else begin
                  s.als   = 1'b0;
                  d.esc_a = 1'b1;
                  put_nb  = 1'b1;
                  do_text = 1'b1;
               end
            end
            PH_TAG: begin
               if (is_alnum(text_byte) && s.tc < TAG_BODY_MAX) begin
                  d.wr_tag = 1'b1;
                  d.wr_idx = IDXW'(s.tc);
                  s.tc     = s.tc + 1'b1;
               end else if (text_byte == US_CHAR && s.tc != '0 && s.tc < TAG_FULL) begin
                  d.wr_tag = 1'b1;
                  d.wr_idx = IDXW'(s.tc);
                  s.tc     = s.tc + 1'b1;
                  s.phase  = PH_TAG_US;
               end else begin
                  // Marker attempt fails: prefix and body go out as text.
                  if (is_alnum(text_byte)) d.ovf = 1'b1;
                  d.pa    = 4'(PREFIX_LEN);
                  d.ta    = s.tc;
                  put_nb  = 1'b1;
                  s.tc    = '0;
                  do_text = 1'b1;
               end
            end
            PH_TAG_US: begin
               if (text_byte == US_CHAR) begin
                  s.tc    = '0;
                  s.phase = PH_TEXT;
               end else begin
                  d.pa    = 4'(PREFIX_LEN);
                  d.ta    = s.tc;
                  put_nb  = 1'b1;
                  s.tc    = '0;
                  do_text = 1'b1;
               end
            end
            default: do_text = 1'b1;
         endcase

         if (do_text) begin
            s.phase = PH_TEXT;
            if (text_byte == ESC_CHAR || text_byte == BEL_CHAR) begin
               if (s.pm != 4'd0) begin
                  s.als  = 1'b0;
                  d.pa   = s.pm;
                  put_nb = 1'b1;
                  s.pm   = 4'd0;
               end
               if (text_byte == ESC_CHAR) s.phase = PH_ESC;
               else s.als = 1'b0;
            end else if (text_byte == prefix_byte(s.pm)) begin
               if (s.pm == 4'(PREFIX_LEN - 1)) begin
                  if (s.als) s.wr = 1'b1;
                  s.als   = 1'b0;
                  s.pm    = 4'd0;
                  s.tc    = '0;
                  s.phase = PH_TAG;
               end else begin
                  s.pm = s.pm + 4'd1;
               end
            end else begin
               keep  = keep_len(s.pm, text_byte);
               s.als = 1'b0;
               if (keep == 4'd0) begin
                  if (s.pm != 4'd0) begin
                     d.pa   = s.pm;
                     put_nb = 1'b1;
                  end
                  put_c = 1'b1;
               end else begin
                  d.pa   = s.pm + 4'd1 - keep;
                  put_nb = 1'b1;
               end
               s.pm = keep;
            end
         end
      end

      // First byte put into an undecided wrapper line releases the held blanks.
      if (put_nb && s.wr && !s.cm) begin
         d.nb = s.bc;
         s.bc = '0;
         s.cm = 1'b1;
      end
      if (put_c) begin
         if (is_blank(text_byte) && s.wr && !s.cm) begin
            if (s.bc < BLANK_FULL) begin
               d.wr_blank = 1'b1;
               d.wr_idx   = IDXW'(s.bc);
               s.bc       = s.bc + 1'b1;
            end else begin
               d.ovf    = 1'b1;
               d.nb     = s.bc;
               s.bc     = '0;
               s.cm     = 1'b1;
               d.emit_c = 1'b1;
            end
         end else begin
            if (s.wr && !s.cm) begin
               d.nb = s.bc;
               s.bc = '0;
               s.cm = 1'b1;
            end
            d.emit_c = 1'b1;
         end
      end

      if (text_byte == NL_CHAR || end_of_text) begin
         unique case (s.phase)
            PH_TEXT: begin
               if (s.pm != 4'd0) begin
                  d.pb = s.pm;
                  endp = 1'b1;
               end
            end
            PH_ESC: begin
               d.esc_b = 1'b1;
               endp    = 1'b1;
            end
            PH_TAG, PH_TAG_US: begin
               d.pb = 4'(PREFIX_LEN);
               d.tb = s.tc;
               endp = 1'b1;
            end
            default: ;
         endcase
         if (endp && s.wr && !s.cm) begin
            d.nb = s.bc;
            s.cm = 1'b1;
         end
         d.nl = (text_byte == NL_CHAR) && !(s.wr && !s.cm);
         s    = FRONT_RESET;
      end

      d.bare = end_of_text && d.nb == '0 && !d.esc_a && d.pa == 4'd0 && d.ta == '0 &&
               !d.emit_c && d.pb == 4'd0 && !d.esc_b && d.tb == '0 && !d.nl;
      state_in = s;
      cmd      = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/tefs_queue.sv]
// Short command queue between the front end and the output sequencer.
module tefs_queue import tefs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]     count_ff, count_in;

   assign full       = count_ff == (QAW+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rp_ff];

   always_comb begin
      wp_in    = push ? wp_ff + 1'b1 : wp_ff;
      rp_in    = pop ? rp_ff + 1'b1 : rp_ff;
      count_in = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wp_ff] <= push_cmd;
   end

endmodule

[rtl/tefs_back.sv]
// Back end: walks each command's segments, reads the hold stores, drives results.
module tefs_back import tefs_pkg::*; #(
   parameter int BLANK_DEPTH = BLANK_DEPTH_DEF,
   parameter int TAG_DEPTH   = TAG_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_has,
   output logic       out_last,
   output logic       out_done,
   output logic       out_ovf
);

   localparam int TAG_AW   = $clog2(TAG_DEPTH);
   localparam int BLANK_AW = $clog2(BLANK_DEPTH);

   logic [7:0]      tag_mem_ff   [TAG_DEPTH];
   logic [7:0]      blank_mem_ff [BLANK_DEPTH];
   logic [7:0]      tag_rd_ff, blank_rd_ff;

   seg_type         seg_ff, seg_in;
   logic [IDXW-1:0] cnt_ff, cnt_in;
   logic            fresh_ff, fresh_in;
   logic [NEMW-1:0] nemit_ff, nemit_in;

   slot_type        s2_ff;
   logic            s2_valid_ff;
   logic [7:0]      ob_ff;
   logic            ov_ff, oh_ff, ol_ff, od_ff, oo_ff;

   logic [IDXW-1:0] len [SEG_COUNT];
   logic            found, more, last, issue, issue_ok, s2_move, store_we;
   seg_type         pick;
   logic [IDXW-1:0] idx;
   slot_type        slot;
   logic [7:0]      s2_byte;

   always_comb begin
      len[SEG_BLANK] = IDXW'(head_cmd.nb);
      len[SEG_ESC_A] = IDXW'(head_cmd.esc_a);
      len[SEG_PFX_A] = IDXW'(head_cmd.pa);
      len[SEG_TAG_A] = IDXW'(head_cmd.ta);
      len[SEG_C]     = IDXW'(head_cmd.emit_c);
      len[SEG_PFX_B] = IDXW'(head_cmd.pb);
      len[SEG_ESC_B] = IDXW'(head_cmd.esc_b);
      len[SEG_TAG_B] = IDXW'(head_cmd.tb);
      len[SEG_NL]    = IDXW'(head_cmd.nl);
      len[SEG_BARE]  = IDXW'(head_cmd.bare);
   end

   // First segment with bytes left, and whether anything follows it.
   always_comb begin
      found = 1'b0;
      pick  = SEG_BLANK;
      idx   = '0;
      for (int s = SEG_COUNT - 1; s >= 0; s--) begin
         if ((4'(s) > seg_ff && len[s] != '0) || (4'(s) == seg_ff && cnt_ff < len[s])) begin
            found = 1'b1;
            pick  = seg_type'(s);
            idx   = (4'(s) == seg_ff) ? cnt_ff : '0;
         end
      end
      more = (idx + 1'b1) < len[pick];
      for (int s = 0; s < SEG_COUNT; s++) begin
         if (4'(s) > pick && len[s] != '0) more = 1'b1;
      end
      last = !more || nemit_ff == '1;
   end

   assign s2_move  = s2_valid_ff && (!ov_ff || out_ready);
   assign issue_ok = !s2_valid_ff || s2_move;
   assign issue    = head_valid && found && issue_ok;
   assign pop      = head_valid && (!found || (issue_ok && last));
   assign store_we = head_valid && fresh_ff && (!found || issue_ok);

   always_comb begin
      slot.seg  = pick;
      slot.idx  = idx;
      slot.c    = head_cmd.c;
      slot.last = last;
      slot.eot  = head_cmd.eot;
      slot.ovf  = head_cmd.ovf;
   end

   always_comb begin
      seg_in   = seg_ff;
      cnt_in   = cnt_ff;
      fresh_in = fresh_ff;
      nemit_in = nemit_ff;
      if (pop) begin
         seg_in   = SEG_BLANK;
         cnt_in   = '0;
         fresh_in = 1'b1;
         nemit_in = '0;
      end else if (issue) begin
         seg_in   = pick;
         cnt_in   = idx + 1'b1;
         fresh_in = 1'b0;
         nemit_in = nemit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff      <= SEG_BLANK;
         cnt_ff      <= '0;
         fresh_ff    <= 1'b1;
         nemit_ff    <= '0;
         s2_valid_ff <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         cnt_ff   <= cnt_in;
         fresh_ff <= fresh_in;
         nemit_ff <= nemit_in;
         if (issue_ok) s2_valid_ff <= issue;
         if (s2_move) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we && head_cmd.wr_tag) tag_mem_ff[head_cmd.wr_idx[TAG_AW-1:0]] <= head_cmd.c;
      if (store_we && head_cmd.wr_blank) begin
         blank_mem_ff[head_cmd.wr_idx[BLANK_AW-1:0]] <= head_cmd.c;
      end
      if (issue) begin
         s2_ff       <= slot;
         tag_rd_ff   <= tag_mem_ff[idx[TAG_AW-1:0]];
         blank_rd_ff <= blank_mem_ff[idx[BLANK_AW-1:0]];
      end
   end

   always_comb begin
      unique case (s2_ff.seg)
         SEG_BLANK:            s2_byte = blank_rd_ff;
         SEG_ESC_A, SEG_ESC_B: s2_byte = ESC_CHAR;
         SEG_PFX_A, SEG_PFX_B: s2_byte = prefix_byte(s2_ff.idx[3:0]);
         SEG_TAG_A, SEG_TAG_B: s2_byte = tag_rd_ff;
         SEG_C:                s2_byte = s2_ff.c;
         SEG_NL:               s2_byte = NL_CHAR;
         default:              s2_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         ob_ff <= s2_byte;
         oh_ff <= s2_ff.seg != SEG_BARE;
         ol_ff <= s2_ff.last;
         od_ff <= s2_ff.last && s2_ff.eot;
         oo_ff <= s2_ff.ovf;
      end
   end

   assign out_valid = ov_ff;
   assign out_byte  = ob_ff;
   assign out_has   = oh_ff;
   assign out_last  = ol_ff;
   assign out_done  = od_ff;
   assign out_ovf   = oo_ff;

   a_bare_closes_text: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !oh_ff |-> ol_ff && od_ff)
      else $error("bare end marker without end of run and end of text");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      ov_ff && od_ff |-> ol_ff)
      else $error("end of text flagged on a result that does not end its run");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      issue && last |=> fresh_ff && seg_ff == SEG_BLANK && cnt_ff == '0)
      else $error("sequencer not rearmed after the last result of a command");

endmodule
